// File: rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the i2c master status sequencer: commands,
// transfer phases, controller status codes, control bit patterns and
// result codes.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BEGIN  = 2'd1,
        CMD_EVENT  = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_STOP = 2'd0,
        PH_SEND = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] REG_TX_COUNT   = 2'd1;
    localparam logic [1:0] REG_RX_COUNT   = 2'd2;

    // controller status codes
    localparam logic [7:0] ST_START         = 8'h08;
    localparam logic [7:0] ST_RESTART       = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK     = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK    = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK    = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK   = 8'h30;
    localparam logic [7:0] ST_ARB_LOST      = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK     = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK    = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK    = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK   = 8'h58;
    localparam logic [7:0] ST_ARB_LOST_SLA  = 8'h68;
    localparam logic [7:0] ST_ARB_LOST_GC   = 8'h78;
    localparam logic [7:0] ST_ARB_LOST_SLAR = 8'hB0;

    // control bits: start, stop, interrupt clear, acknowledge
    localparam logic [3:0] CB_NONE   = 4'h0;
    localparam logic [3:0] CB_SI     = 4'h2;
    localparam logic [3:0] CB_SI_AA  = 4'h3;
    localparam logic [3:0] CB_STO_SI = 4'h6;
    localparam logic [3:0] CB_STA_SI = 4'hA;

    // interrupt change codes
    localparam logic [1:0] IC_NONE    = 2'd0;
    localparam logic [1:0] IC_ENABLE  = 2'd1;
    localparam logic [1:0] IC_DISABLE = 2'd2;

    // completion codes
    localparam logic [1:0] COMP_NONE  = 2'd0;
    localparam logic [1:0] COMP_DONE  = 2'd1;
    localparam logic [1:0] COMP_ERROR = 2'd2;

    // error bits
    localparam logic [3:0] ERR_TIMEOUT = 4'h1;
    localparam logic [3:0] ERR_ARB     = 4'h2;
    localparam logic [3:0] ERR_NACK    = 4'h4;
    localparam logic [3:0] ERR_OVERRUN = 4'h8;

endpackage

// File: rtl/i2c_master_status_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer
// Pipeline: an accepted request is registered with its transmit buffer read,
// then decoded into the output register.
// Throughput: one request per cycle unless out_ready stalls; the next buffer
// read is issued while the current request is decoded, with a write bypass.
// Reset: asynchronous, clears master flag, phase, indices, errors and
// configuration; buffer contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module i2c_master_status_sequencer #(
    parameter int TX_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // request channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] tx_byte,
    input  logic       direction,
    input  logic [7:0] status_code,
    input  logic       timeout_flag,
    input  logic [7:0] rx_data,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic       control_write,
    output logic [3:0] control_bits,
    output logic       data_write,
    output logic [7:0] data_byte,
    output logic [1:0] int_change,
    output logic       rx_valid,
    output logic [7:0] rx_byte,
    output logic [7:0] rx_position,
    output logic [1:0] completion,
    output logic [3:0] error_bits,
    output logic       clear_timeout
);

    localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int PW = $clog2(TX_DEPTH + 1);
    localparam int CW = (PW > 5) ? PW : 5;

    // configuration registers
    logic [6:0] slave_addr_reg;
    logic [4:0] tx_count_reg;
    logic [7:0] rx_count_reg;

    // sequencer state
    logic                 master_reg, master_next;
    i2cms_pkg::phase_t    phase_reg, phase_next;
    logic [PW-1:0]        tx_pos_reg, tx_pos_next;
    logic [7:0]           rx_cnt_reg, rx_cnt_next;
    logic [3:0]           err_reg, err_next;
    logic [PW-1:0]        load_ptr_reg, load_ptr_next;

    // request stage
    logic                 s1_valid_reg;
    i2cms_pkg::cmd_t      s1_cmd_reg;
    logic [7:0]           s1_tx_byte_reg;
    logic                 s1_dir_reg;
    logic [7:0]           s1_status_reg;
    logic                 s1_tmo_reg;
    logic [7:0]           s1_rx_data_reg;
    logic                 fwd_hit_reg;
    logic [7:0]           fwd_data_reg;

    // output register
    logic                 out_valid_reg;
    logic                 cw_reg, dw_reg, rv_reg, ct_reg;
    logic [3:0]           cb_reg, eb_reg;
    logic [7:0]           db_reg, rb_reg, rp_reg;
    logic [1:0]           ic_reg, comp_reg;

    // results of the current request
    logic                 res_cw, res_dw, res_rv, res_ct;
    logic [3:0]           res_cb;
    logic [7:0]           res_db, res_rb, res_rp;
    logic [1:0]           res_ic, res_comp;

    logic                 in_fire, s1_fire;
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [7:0]           ram_rdata, tx_data;

    logic                 is_start, is_arb, is_tx_ack, is_nack, is_rx_data;
    logic                 mf_eff, tx_more, buf_room;
    logic                 rx_overrun, rx_last_pre, rx_done, rx_last_post;
    logic [7:0]           rx_inc;

    assign cfg_ready = 1'b1;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_fire   = in_valid && in_ready;

    // status decode
    assign is_start   = (s1_status_reg == i2cms_pkg::ST_START) ||
                        (s1_status_reg == i2cms_pkg::ST_RESTART);
    assign is_arb     = (s1_status_reg == i2cms_pkg::ST_ARB_LOST) ||
                        (s1_status_reg == i2cms_pkg::ST_ARB_LOST_SLA) ||
                        (s1_status_reg == i2cms_pkg::ST_ARB_LOST_GC) ||
                        (s1_status_reg == i2cms_pkg::ST_ARB_LOST_SLAR);
    assign is_tx_ack  = (s1_status_reg == i2cms_pkg::ST_SLA_W_ACK) ||
                        (s1_status_reg == i2cms_pkg::ST_DATA_W_ACK);
    assign is_nack    = (s1_status_reg == i2cms_pkg::ST_SLA_W_NACK) ||
                        (s1_status_reg == i2cms_pkg::ST_DATA_W_NACK) ||
                        (s1_status_reg == i2cms_pkg::ST_SLA_R_NACK);
    assign is_rx_data = (s1_status_reg == i2cms_pkg::ST_DATA_R_ACK) ||
                        (s1_status_reg == i2cms_pkg::ST_DATA_R_NACK);

    assign mf_eff       = master_reg || is_start;
    assign tx_more      = (CW'(tx_pos_reg) < CW'(tx_count_reg)) &&
                          (tx_pos_reg < PW'(TX_DEPTH));
    assign buf_room     = load_ptr_reg < PW'(TX_DEPTH);
    assign rx_overrun   = (rx_count_reg == 8'd0) || (rx_cnt_reg >= rx_count_reg);
    assign rx_inc       = rx_cnt_reg + 8'd1;
    assign rx_last_pre  = ({1'b0, rx_cnt_reg} + 9'd1) == {1'b0, rx_count_reg};
    assign rx_done      = rx_inc == rx_count_reg;
    assign rx_last_post = ({1'b0, rx_inc} + 9'd1) == {1'b0, rx_count_reg};

    assign tx_data = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    // next state
    always_comb
    begin
        master_next   = master_reg;
        phase_next    = phase_reg;
        tx_pos_next   = tx_pos_reg;
        rx_cnt_next   = rx_cnt_reg;
        err_next      = err_reg;
        load_ptr_next = load_ptr_reg;
        unique case (s1_cmd_reg)
            i2cms_pkg::CMD_LOAD:
            begin
                if (buf_room)
                begin
                    load_ptr_next = load_ptr_reg + PW'(1);
                end
            end
            i2cms_pkg::CMD_BEGIN:
            begin
                phase_next  = s1_dir_reg ? i2cms_pkg::PH_RECV : i2cms_pkg::PH_SEND;
                err_next    = 4'h0;
                tx_pos_next = '0;
                rx_cnt_next = 8'd0;
                if (!master_reg && is_start)
                begin
                    master_next = 1'b1;
                end
            end
            i2cms_pkg::CMD_FINISH:
            begin
                master_next   = 1'b0;
                load_ptr_next = '0;
            end
            i2cms_pkg::CMD_EVENT:
            begin
                priority if (s1_tmo_reg)
                begin
                    err_next = err_reg | i2cms_pkg::ERR_TIMEOUT;
                end
                else if (is_start && phase_reg == i2cms_pkg::PH_STOP)
                begin
                    master_next = master_reg;
                end
                else if (mf_eff)
                begin
                    master_next = 1'b1;
                    priority if (is_arb)
                    begin
                        err_next    = err_reg | i2cms_pkg::ERR_ARB;
                        master_next = 1'b0;
                    end
                    else if (is_tx_ack)
                    begin
                        priority if (is_start)
                        begin
                            phase_next = phase_reg;
                        end
                        else if (tx_more)
                        begin
                            tx_pos_next = tx_pos_reg + PW'(1);
                        end
                        else if (rx_count_reg != 8'd0)
                        begin
                            phase_next = i2cms_pkg::PH_RECV;
                        end
                        else
                        begin
                            phase_next = i2cms_pkg::PH_STOP;
                        end
                    end
                    else if (is_nack)
                    begin
                        err_next   = err_reg | i2cms_pkg::ERR_NACK;
                        phase_next = i2cms_pkg::PH_STOP;
                    end
                    else if (is_rx_data)
                    begin
                        if (rx_overrun)
                        begin
                            err_next   = err_reg | i2cms_pkg::ERR_OVERRUN;
                            phase_next = i2cms_pkg::PH_STOP;
                        end
                        else
                        begin
                            rx_cnt_next = rx_inc;
                            if (rx_done)
                            begin
                                phase_next = i2cms_pkg::PH_STOP;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg;
                    end
                end
                else
                begin
                    master_next = master_reg;
                end
            end
        endcase
    end

    // result of the current request
    always_comb
    begin
        logic woke;
        woke     = 1'b0;
        res_cw   = 1'b0;
        res_cb   = i2cms_pkg::CB_NONE;
        res_dw   = 1'b0;
        res_db   = 8'd0;
        res_ic   = i2cms_pkg::IC_NONE;
        res_rv   = 1'b0;
        res_rb   = 8'd0;
        res_rp   = 8'd0;
        res_comp = i2cms_pkg::COMP_NONE;
        res_ct   = 1'b0;
        unique case (s1_cmd_reg)
            i2cms_pkg::CMD_LOAD:
            begin
                res_cw = 1'b0;
            end
            i2cms_pkg::CMD_BEGIN:
            begin
                if (!master_reg && is_start)
                begin
                    res_ic = i2cms_pkg::IC_ENABLE;
                end
                else
                begin
                    res_cw = 1'b1;
                    res_cb = i2cms_pkg::CB_STA_SI;
                end
            end
            i2cms_pkg::CMD_FINISH:
            begin
                res_ct = 1'b1;
            end
            i2cms_pkg::CMD_EVENT:
            begin
                priority if (s1_tmo_reg)
                begin
                    res_ct = 1'b1;
                    res_cw = 1'b1;
                    res_cb = i2cms_pkg::CB_SI;
                end
                else if (is_start && phase_reg == i2cms_pkg::PH_STOP)
                begin
                    res_ic = i2cms_pkg::IC_DISABLE;
                end
                else
                begin
                    if (mf_eff)
                    begin
                        priority if (is_arb)
                        begin
                            res_cw = 1'b1;
                            res_cb = i2cms_pkg::CB_SI;
                        end
                        else if (is_start)
                        begin
                            res_dw = 1'b1;
                            res_db = {slave_addr_reg, phase_reg != i2cms_pkg::PH_SEND};
                            res_cw = 1'b1;
                            res_cb = i2cms_pkg::CB_SI;
                        end
                        else if (is_tx_ack)
                        begin
                            res_cw = 1'b1;
                            priority if (tx_more)
                            begin
                                res_dw = 1'b1;
                                res_db = tx_data;
                                res_cb = i2cms_pkg::CB_SI;
                            end
                            else if (rx_count_reg != 8'd0)
                            begin
                                res_cb = i2cms_pkg::CB_STA_SI;
                            end
                            else
                            begin
                                res_cb = i2cms_pkg::CB_STO_SI;
                                woke   = 1'b1;
                            end
                        end
                        else if (is_nack)
                        begin
                            res_cw = 1'b1;
                            res_cb = i2cms_pkg::CB_STO_SI;
                        end
                        else if (s1_status_reg == i2cms_pkg::ST_SLA_R_ACK)
                        begin
                            res_cw = 1'b1;
                            res_cb = rx_last_pre ? i2cms_pkg::CB_SI : i2cms_pkg::CB_SI_AA;
                        end
                        else if (is_rx_data)
                        begin
                            res_cw = 1'b1;
                            if (rx_overrun)
                            begin
                                res_cb = i2cms_pkg::CB_STO_SI;
                            end
                            else
                            begin
                                res_rv = 1'b1;
                                res_rb = s1_rx_data_reg;
                                res_rp = rx_cnt_reg;
                                priority if (rx_done)
                                begin
                                    res_cb = i2cms_pkg::CB_STO_SI;
                                    woke   = 1'b1;
                                end
                                else if (rx_last_post)
                                begin
                                    res_cb = i2cms_pkg::CB_SI;
                                end
                                else
                                begin
                                    res_cb = i2cms_pkg::CB_SI_AA;
                                end
                            end
                        end
                        else
                        begin
                            res_cw = 1'b0;
                        end
                    end
                    priority if (woke)
                    begin
                        res_comp = i2cms_pkg::COMP_DONE;
                    end
                    else if (err_next != 4'h0)
                    begin
                        res_comp = i2cms_pkg::COMP_ERROR;
                    end
                    else if (phase_next == i2cms_pkg::PH_STOP && !master_next)
                    begin
                        res_comp = i2cms_pkg::COMP_DONE;
                    end
                    else
                    begin
                        res_comp = i2cms_pkg::COMP_NONE;
                    end
                end
            end
        endcase
    end

    // transmit buffer
    assign ram_we    = s1_fire && (s1_cmd_reg == i2cms_pkg::CMD_LOAD) && buf_room;
    assign ram_waddr = load_ptr_reg[AW-1:0];
    assign ram_re    = in_fire;
    assign ram_raddr = s1_fire ? tx_pos_next[AW-1:0] : tx_pos_reg[AW-1:0];

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH),
        .AW    (AW)
    ) u_tx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s1_tx_byte_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 7'd0;
            tx_count_reg   <= 5'd0;
            rx_count_reg   <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                i2cms_pkg::REG_SLAVE_ADDR: slave_addr_reg <= cfg_data[6:0];
                i2cms_pkg::REG_TX_COUNT:   tx_count_reg   <= cfg_data[4:0];
                i2cms_pkg::REG_RX_COUNT:   rx_count_reg   <= cfg_data;
                default:                   slave_addr_reg <= slave_addr_reg;
            endcase
        end
    end

    // state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg    <= 1'b0;
            phase_reg     <= i2cms_pkg::PH_STOP;
            tx_pos_reg    <= '0;
            rx_cnt_reg    <= 8'd0;
            err_reg       <= 4'h0;
            load_ptr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                master_reg   <= master_next;
                phase_reg    <= phase_next;
                tx_pos_reg   <= tx_pos_next;
                rx_cnt_reg   <= rx_cnt_next;
                err_reg      <= err_next;
                load_ptr_reg <= load_ptr_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (in_fire)
            begin
                fwd_hit_reg <= ram_we && (ram_waddr == ram_raddr);
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg     <= i2cms_pkg::cmd_t'(command);
            s1_tx_byte_reg <= tx_byte;
            s1_dir_reg     <= direction;
            s1_status_reg  <= status_code;
            s1_tmo_reg     <= timeout_flag;
            s1_rx_data_reg <= rx_data;
            fwd_data_reg   <= s1_tx_byte_reg;
        end
        if (s1_fire)
        begin
            cw_reg   <= res_cw;
            cb_reg   <= res_cb;
            dw_reg   <= res_dw;
            db_reg   <= res_db;
            ic_reg   <= res_ic;
            rv_reg   <= res_rv;
            rb_reg   <= res_rb;
            rp_reg   <= res_rp;
            comp_reg <= res_comp;
            eb_reg   <= err_next;
            ct_reg   <= res_ct;
        end
    end

    assign out_valid     = out_valid_reg;
    assign control_write = cw_reg;
    assign control_bits  = cb_reg;
    assign data_write    = dw_reg;
    assign data_byte     = db_reg;
    assign int_change    = ic_reg;
    assign rx_valid      = rv_reg;
    assign rx_byte       = rb_reg;
    assign rx_position   = rp_reg;
    assign completion    = comp_reg;
    assign error_bits    = eb_reg;
    assign clear_timeout = ct_reg;

endmodule

// File: rtl/i2cms_ram.sv
// ----------------------------------------------------------------------------
// i2cms_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks on the result channel of the sequencer.
// ----------------------------------------------------------------------------
module i2cms_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       control_write,
    input logic [3:0] control_bits,
    input logic       data_write,
    input logic [7:0] data_byte,
    input logic       rx_valid,
    input logic [7:0] rx_byte,
    input logic [7:0] rx_position,
    input logic [1:0] completion,
    input logic [1:0] int_change
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(control_bits) &&
        $stable(data_byte) && $stable(completion))
        else $error("stalled result changed");

    a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !control_write |-> control_bits == i2cms_pkg::CB_NONE)
        else $error("control bits without control write");

    a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rx_valid |-> rx_byte == 8'd0 && rx_position == 8'd0)
        else $error("received byte without rx valid");

    a_data_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_write |-> control_write && !rx_valid &&
        int_change == i2cms_pkg::IC_NONE)
        else $error("data write mixed with other actions");

endmodule

bind i2c_master_status_sequencer i2cms_checker u_i2cms_checker (.*);

// File: tb/tb_i2c_master_status_sequencer.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_status_sequencer
// Self-checking bench for the i2c master status sequencer. A behavioral
// predictor tracks the master flag, transfer phase, byte indices, error bits
// and transmit buffer, and queues the controller action due for every
// accepted request. Corner cases run first, then full write and read
// transfers at the extremes of the registers, then random transfers with
// injected bus faults under request gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb_i2c_master_status_sequencer;

    localparam int CLK_PERIOD = 12;
    localparam int BUF_DEPTH = 16;
    localparam int DRAIN_CYCLES = 4;
    localparam int RUN_LIMIT_CYCLES = 200000;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam logic [7:0] ST_UNKNOWN = 8'hF8;

    typedef struct packed {
        logic       control_write;
        logic [3:0] control_bits;
        logic       data_write;
        logic [7:0] data_byte;
        logic [1:0] int_change;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_position;
        logic [1:0] completion;
        logic [3:0] error_bits;
        logic       clear_timeout;
    } ctrl_action_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] command = i2cms_pkg::CMD_LOAD;
    logic [7:0] tx_byte = '0;
    logic       direction = 1'b0;
    logic [7:0] status_code = '0;
    logic       timeout_flag = 1'b0;
    logic [7:0] rx_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       control_write;
    logic [3:0] control_bits;
    logic       data_write;
    logic [7:0] data_byte;
    logic [1:0] int_change;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_position;
    logic [1:0] completion;
    logic [3:0] error_bits;
    logic       clear_timeout;

    // predictor copy of registers and state
    logic [6:0]           slave_addr_q = '0;
    logic [4:0]           tx_count_q = '0;
    logic [7:0]           rx_count_q = '0;
    logic                 master_q = 1'b0;
    i2cms_pkg::phase_t    phase_q = i2cms_pkg::PH_STOP;
    logic [4:0]           tx_pos_q = '0;
    logic [7:0]           rx_cnt_q = '0;
    logic [3:0]           err_q = '0;
    logic [4:0]           load_ptr_q = '0;
    logic [7:0]           tx_buf [BUF_DEPTH];
    logic [BUF_DEPTH-1:0] tx_loaded = '0;

    ctrl_action_t actions_due [$];
    int           mismatch_count = 0;
    int           requests_counted = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           noise_pct = 0;

    logic [7:0] bus_faults [7] = '{i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_W_NACK,
                                   i2cms_pkg::ST_SLA_R_NACK, i2cms_pkg::ST_ARB_LOST,
                                   i2cms_pkg::ST_ARB_LOST_SLA, i2cms_pkg::ST_ARB_LOST_GC,
                                   i2cms_pkg::ST_ARB_LOST_SLAR};

    i2c_master_status_sequencer #(
        .TX_DEPTH(BUF_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .tx_byte(tx_byte),
        .direction(direction),
        .status_code(status_code),
        .timeout_flag(timeout_flag),
        .rx_data(rx_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .control_write(control_write),
        .control_bits(control_bits),
        .data_write(data_write),
        .data_byte(data_byte),
        .int_change(int_change),
        .rx_valid(rx_valid),
        .rx_byte(rx_byte),
        .rx_position(rx_position),
        .completion(completion),
        .error_bits(error_bits),
        .clear_timeout(clear_timeout)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    function automatic logic [4:0] tx_limit();
        return (tx_count_q < BUF_DEPTH) ? tx_count_q : 5'(BUF_DEPTH);
    endfunction

    function automatic ctrl_action_t predict_action(input i2cms_pkg::cmd_t cmd_i,
                                                    input logic [7:0] txb,
                                                    input logic dir, input logic [7:0] st,
                                                    input logic tmo, input logic [7:0] rxd);
        ctrl_action_t a;
        logic         woke;
        logic         start_seen;
        a = '0;
        woke = 1'b0;
        start_seen = (st == i2cms_pkg::ST_START) || (st == i2cms_pkg::ST_RESTART);
        case (cmd_i)
            i2cms_pkg::CMD_LOAD:
            begin
                if (load_ptr_q < BUF_DEPTH)
                begin
                    tx_buf[load_ptr_q[3:0]] = txb;
                    tx_loaded[load_ptr_q[3:0]] = 1'b1;
                    load_ptr_q = load_ptr_q + 5'd1;
                end
            end
            i2cms_pkg::CMD_BEGIN:
            begin
                phase_q = dir ? i2cms_pkg::PH_RECV : i2cms_pkg::PH_SEND;
                err_q = '0;
                tx_pos_q = '0;
                rx_cnt_q = '0;
                if (!master_q && start_seen)
                begin
                    master_q = 1'b1;
                    a.int_change = i2cms_pkg::IC_ENABLE;
                end
                else
                begin
                    a.control_write = 1'b1;
                    a.control_bits = i2cms_pkg::CB_STA_SI;
                end
            end
            i2cms_pkg::CMD_FINISH:
            begin
                master_q = 1'b0;
                a.clear_timeout = 1'b1;
                load_ptr_q = '0;
            end
            default:
            begin
                if (tmo)
                begin
                    err_q = err_q | i2cms_pkg::ERR_TIMEOUT;
                    a.clear_timeout = 1'b1;
                    a.control_write = 1'b1;
                    a.control_bits = i2cms_pkg::CB_SI;
                end
                else if (start_seen && phase_q == i2cms_pkg::PH_STOP)
                    a.int_change = i2cms_pkg::IC_DISABLE;
                else
                begin
                    if (start_seen)
                        master_q = 1'b1;
                    if (master_q)
                    begin
                        case (st)
                            i2cms_pkg::ST_ARB_LOST, i2cms_pkg::ST_ARB_LOST_SLA,
                            i2cms_pkg::ST_ARB_LOST_GC, i2cms_pkg::ST_ARB_LOST_SLAR:
                            begin
                                err_q = err_q | i2cms_pkg::ERR_ARB;
                                a.control_write = 1'b1;
                                a.control_bits = i2cms_pkg::CB_SI;
                                master_q = 1'b0;
                            end
                            i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART:
                            begin
                                a.data_write = 1'b1;
                                a.data_byte = {slave_addr_q, (phase_q != i2cms_pkg::PH_SEND)};
                                a.control_write = 1'b1;
                                a.control_bits = i2cms_pkg::CB_SI;
                            end
                            i2cms_pkg::ST_SLA_W_ACK, i2cms_pkg::ST_DATA_W_ACK:
                            begin
                                a.control_write = 1'b1;
                                if (tx_pos_q < tx_limit())
                                begin
                                    a.data_write = 1'b1;
                                    a.data_byte = tx_buf[tx_pos_q[3:0]];
                                    tx_pos_q = tx_pos_q + 5'd1;
                                    a.control_bits = i2cms_pkg::CB_SI;
                                end
                                else if (rx_count_q != 8'd0)
                                begin
                                    phase_q = i2cms_pkg::PH_RECV;
                                    a.control_bits = i2cms_pkg::CB_STA_SI;
                                end
                                else
                                begin
                                    phase_q = i2cms_pkg::PH_STOP;
                                    a.control_bits = i2cms_pkg::CB_STO_SI;
                                    woke = 1'b1;
                                end
                            end
                            i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_W_NACK,
                            i2cms_pkg::ST_SLA_R_NACK:
                            begin
                                err_q = err_q | i2cms_pkg::ERR_NACK;
                                phase_q = i2cms_pkg::PH_STOP;
                                a.control_write = 1'b1;
                                a.control_bits = i2cms_pkg::CB_STO_SI;
                            end
                            i2cms_pkg::ST_SLA_R_ACK:
                            begin
                                a.control_write = 1'b1;
                                a.control_bits = (int'(rx_cnt_q) + 1 == int'(rx_count_q)) ?
                                                 i2cms_pkg::CB_SI : i2cms_pkg::CB_SI_AA;
                            end
                            i2cms_pkg::ST_DATA_R_ACK, i2cms_pkg::ST_DATA_R_NACK:
                            begin
                                a.control_write = 1'b1;
                                if (rx_count_q == 8'd0 || rx_cnt_q >= rx_count_q)
                                begin
                                    err_q = err_q | i2cms_pkg::ERR_OVERRUN;
                                    phase_q = i2cms_pkg::PH_STOP;
                                    a.control_bits = i2cms_pkg::CB_STO_SI;
                                end
                                else
                                begin
                                    a.rx_valid = 1'b1;
                                    a.rx_byte = rxd;
                                    a.rx_position = rx_cnt_q;
                                    rx_cnt_q = rx_cnt_q + 8'd1;
                                    if (rx_cnt_q == rx_count_q)
                                    begin
                                        phase_q = i2cms_pkg::PH_STOP;
                                        a.control_bits = i2cms_pkg::CB_STO_SI;
                                        woke = 1'b1;
                                    end
                                    else if (int'(rx_cnt_q) + 1 == int'(rx_count_q))
                                        a.control_bits = i2cms_pkg::CB_SI;
                                    else
                                        a.control_bits = i2cms_pkg::CB_SI_AA;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    if (woke)
                        a.completion = i2cms_pkg::COMP_DONE;
                    else if (err_q != 4'h0)
                        a.completion = i2cms_pkg::COMP_ERROR;
                    else if (phase_q == i2cms_pkg::PH_STOP && !master_q)
                        a.completion = i2cms_pkg::COMP_DONE;
                end
            end
        endcase
        a.error_bits = err_q;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int expv, input int gotv);
        $display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h", $time, what, expv, gotv);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        ctrl_action_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (actions_due.size() == 0)
                report_mismatch("result with no request pending", 0, 1);
            else
            begin
                due = actions_due.pop_front();
                if (control_write !== due.control_write)
                    report_mismatch("control_write", int'(due.control_write),
                                    int'(control_write));
                if (control_bits !== due.control_bits)
                    report_mismatch("control_bits", int'(due.control_bits),
                                    int'(control_bits));
                if (data_write !== due.data_write)
                    report_mismatch("data_write", int'(due.data_write), int'(data_write));
                if (data_byte !== due.data_byte)
                    report_mismatch("data_byte", int'(due.data_byte), int'(data_byte));
                if (int_change !== due.int_change)
                    report_mismatch("int_change", int'(due.int_change), int'(int_change));
                if (rx_valid !== due.rx_valid)
                    report_mismatch("rx_valid", int'(due.rx_valid), int'(rx_valid));
                if (rx_byte !== due.rx_byte)
                    report_mismatch("rx_byte", int'(due.rx_byte), int'(rx_byte));
                if (rx_position !== due.rx_position)
                    report_mismatch("rx_position", int'(due.rx_position), int'(rx_position));
                if (completion !== due.completion)
                    report_mismatch("completion", int'(due.completion), int'(completion));
                if (error_bits !== due.error_bits)
                    report_mismatch("error_bits", int'(due.error_bits), int'(error_bits));
                if (clear_timeout !== due.clear_timeout)
                    report_mismatch("clear_timeout", int'(due.clear_timeout),
                                    int'(clear_timeout));
            end
        end
    end

    task automatic send_request(input i2cms_pkg::cmd_t cmd_i, input logic [7:0] txb,
                                input logic dir, input logic [7:0] st, input logic tmo,
                                input logic [7:0] rxd);
        logic ignored;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        // never send a buffer entry that was not loaded since reset
        if (cmd_i == i2cms_pkg::CMD_EVENT && !tmo &&
            (st == i2cms_pkg::ST_SLA_W_ACK || st == i2cms_pkg::ST_DATA_W_ACK)
            && master_q && tx_pos_q < tx_limit() && !tx_loaded[tx_pos_q[3:0]])
            st = i2cms_pkg::ST_SLA_R_ACK;
        in_valid <= 1'b1;
        command <= cmd_i;
        tx_byte <= txb;
        direction <= dir;
        status_code <= st;
        timeout_flag <= tmo;
        rx_data <= rxd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ignored = (cmd_i == i2cms_pkg::CMD_LOAD) && (load_ptr_q >= BUF_DEPTH);
        actions_due.push_back(predict_action(cmd_i, txb, dir, st, tmo, rxd));
        if (!ignored)
            requests_counted++;
    endtask

    task automatic send_event(input logic [7:0] st);
        logic tmo;
        tmo = 1'b0;
        if ($urandom_range(99) < noise_pct)
        begin
            case ($urandom_range(4))
                0: tmo = 1'b1;
                1: st = 8'($urandom_range(255));
                2: st = bus_faults[$urandom_range(6)];
                3: st = ($urandom_range(1) != 0) ? i2cms_pkg::ST_START : i2cms_pkg::ST_RESTART;
                default: st = i2cms_pkg::ST_DATA_R_ACK;
            endcase
        end
        send_request(i2cms_pkg::CMD_EVENT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     st, tmo, 8'($urandom_range(255)));
    endtask

    task automatic send_finish();
        send_request(i2cms_pkg::CMD_FINISH, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     8'($urandom_range(255)), 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    task automatic release_requests();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (actions_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            i2cms_pkg::REG_SLAVE_ADDR: slave_addr_q = value[6:0];
            i2cms_pkg::REG_TX_COUNT:   tx_count_q = value[4:0];
            i2cms_pkg::REG_RX_COUNT:   rx_count_q = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [6:0] addr, input logic [4:0] txc, input logic [7:0] rxc);
        release_requests();
        drain_results();
        write_register(i2cms_pkg::REG_SLAVE_ADDR, {1'($urandom_range(1)), addr});
        write_register(i2cms_pkg::REG_TX_COUNT, {3'($urandom_range(7)), txc});
        write_register(i2cms_pkg::REG_RX_COUNT, rxc);
    endtask

    // loads, begin, address, write bytes, optional restart, read bytes and optional finish
    task automatic run_transfer(input logic dir, input logic overload, input logic finish_it);
        int n_tx;
        int n_rx;
        int n_loads;
        logic [7:0] begin_code;
        n_tx = int'(tx_limit());
        n_rx = int'(rx_count_q);
        n_loads = overload ? int'($urandom_range(BUF_DEPTH + 2)) : n_tx;
        for (int i = 0; i < n_loads; i++)
            send_request(i2cms_pkg::CMD_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         8'($urandom_range(255)), 1'($urandom_range(1)),
                         8'($urandom_range(255)));
        if ($urandom_range(7) == 0)
            begin_code = 8'($urandom_range(255));
        else
            begin_code = ($urandom_range(1) != 0) ? i2cms_pkg::ST_START : i2cms_pkg::ST_RESTART;
        send_request(i2cms_pkg::CMD_BEGIN, 8'($urandom_range(255)), dir, begin_code,
                     1'($urandom_range(1)), 8'($urandom_range(255)));
        send_event(i2cms_pkg::ST_START);
        if (!dir)
        begin
            for (int i = 0; i <= n_tx; i++)
                send_event((i == 0) ? i2cms_pkg::ST_SLA_W_ACK : i2cms_pkg::ST_DATA_W_ACK);
            if (n_rx != 0)
                send_event(i2cms_pkg::ST_RESTART);
        end
        if (dir || n_rx != 0)
        begin
            send_event(i2cms_pkg::ST_SLA_R_ACK);
            for (int i = 0; i < n_rx; i++)
                send_event((i == n_rx - 1) ? i2cms_pkg::ST_DATA_R_NACK :
                           i2cms_pkg::ST_DATA_R_ACK);
        end
        if (finish_it)
            send_finish();
    endtask

    task automatic test_corner_cases();
        idle_pct = 0;
        stall_pct = 0;
        noise_pct = 0;
        write_register(REG_SPARE, 8'hA5);
        configure(7'h7F, 5'd31, 8'd1);
        // start status while stopped, then a write ack while not master
        send_request(i2cms_pkg::CMD_EVENT, 8'h00, 1'b0, i2cms_pkg::ST_START, 1'b0, 8'h00);
        send_request(i2cms_pkg::CMD_EVENT, 8'hFF, 1'b1, i2cms_pkg::ST_SLA_W_ACK, 1'b0, 8'hFF);
        // fill the buffer, last load is dropped
        for (int i = 0; i <= BUF_DEPTH; i++)
            send_request(i2cms_pkg::CMD_LOAD,
                         (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255)),
                         1'b1, 8'hFF, 1'b1, 8'h00);
        send_request(i2cms_pkg::CMD_BEGIN, 8'h00, 1'b0, i2cms_pkg::ST_START, 1'b0, 8'h00);
        send_request(i2cms_pkg::CMD_BEGIN, 8'hFF, 1'b0, i2cms_pkg::ST_START, 1'b0, 8'hFF);
        send_request(i2cms_pkg::CMD_EVENT, 8'h00, 1'b0, i2cms_pkg::ST_START, 1'b0, 8'h00);
        send_request(i2cms_pkg::CMD_EVENT, 8'h00, 1'b0, i2cms_pkg::ST_DATA_W_ACK, 1'b1, 8'h00);
        send_request(i2cms_pkg::CMD_EVENT, 8'hFF, 1'b1, ST_UNKNOWN, 1'b0, 8'hFF);
        send_finish();
    endtask

    task automatic test_extremes();
        idle_pct = 9;
        stall_pct = 9;
        noise_pct = 0;
        configure(7'h00, 5'd16, 8'd255);
        run_transfer(1'b0, 1'b0, 1'b1);
        configure(7'h7F, 5'd31, 8'd0);
        run_transfer(1'b0, 1'b0, 1'b1);
        // read with nothing to receive, then an overrun
        configure(7'h55, 5'd0, 8'd0);
        run_transfer(1'b1, 1'b0, 1'b0);
        send_event(i2cms_pkg::ST_DATA_R_ACK);
        send_finish();
        configure(7'h2A, 5'd0, 8'd1);
        run_transfer(1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int hold_pct, input int target);
        int stop_at;
        idle_pct = gap_pct;
        stall_pct = hold_pct;
        noise_pct = 10;
        stop_at = requests_counted + target;
        while (requests_counted < stop_at)
        begin
            if ($urandom_range(3) == 0)
                configure(7'($urandom_range(127)),
                          5'(($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(4)),
                          8'(($urandom_range(4) == 0) ? $urandom_range(24) : $urandom_range(5)));
            run_transfer($urandom_range(3) == 0, $urandom_range(5) == 0, $urandom_range(7) != 0);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_corner_cases();
        test_extremes();
        test_random_traffic(0, 0, 150);
        test_random_traffic(50, 0, 150);
        test_random_traffic(0, 50, 150);
        test_random_traffic(9, 9, 150);
        release_requests();
        drain_results();
        if (mismatch_count == 0)
            $display("tb_i2c_master_status_sequencer: clean");
        else
            $display("tb_i2c_master_status_sequencer: errors");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("tb_i2c_master_status_sequencer: errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/i2cms_pkg.sv
rtl/i2cms_ram.sv
rtl/i2c_master_status_sequencer.sv
rtl/i2cms_checker.sv
tb/tb_i2c_master_status_sequencer.sv
